// ===== hw/rtl/aspw_pkg.sv =====
package aspw_pkg;

    // field widths fixed by the stream format
    localparam int OP_W     = 2;
    localparam int SAMPLE_W = 16;
    localparam int ADDR_W   = 9;
    localparam int FREE_W   = 7;
    localparam int CFG_W    = 16;

    // sign flip turns a two's complement sample into an offset binary dac code
    localparam logic [SAMPLE_W-1:0] SIGN_FLIP = 16'h8000;

    // opcodes of an input beat
    typedef enum logic [OP_W-1:0] {
        OP_WORD  = 2'd0,
        OP_DONE  = 2'd1,
        OP_START = 2'd2,
        OP_STOP  = 2'd3
    } t_op;

    // configuration register indexes
    typedef enum logic {
        CFG_SAMPLE_RATE = 1'b0,
        CFG_STEREO_MODE = 1'b1
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] SAMPLE_RATE_RESET = 16'd44100;

    // classified command handed from the front to the back
    typedef struct packed {
        logic                is_word;
        logic                is_done;
        logic                is_start;
        logic                is_stop;
        logic [SAMPLE_W-1:0] dac_code;
    } t_cmd;

endpackage

// ===== hw/rtl/aspw_front.sv =====
module aspw_front (
    input  logic                          i_valid,
    input  logic [aspw_pkg::OP_W-1:0]     i_opcode,
    input  logic [aspw_pkg::SAMPLE_W-1:0] i_sample_word,
    input  logic                          i_queue_full,
    output logic                          o_stall,
    output logic                          o_push,
    output aspw_pkg::t_cmd                o_cmd
);

    // accept whenever the queue has room
    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    // decode opcode and precompute the dac code
    always_comb begin
        o_cmd          = '0;
        o_cmd.dac_code = i_sample_word ^ aspw_pkg::SIGN_FLIP;
        unique case (aspw_pkg::t_op'(i_opcode))
            aspw_pkg::OP_WORD:  o_cmd.is_word  = 1'b1;
            aspw_pkg::OP_DONE:  o_cmd.is_done  = 1'b1;
            aspw_pkg::OP_START: o_cmd.is_start = 1'b1;
            aspw_pkg::OP_STOP:  o_cmd.is_stop  = 1'b1;
            default:            o_cmd.is_stop  = 1'b1;
        endcase
    end

endmodule

// ===== hw/rtl/aspw_queue.sv =====
module aspw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  aspw_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output aspw_pkg::t_cmd o_cmd
);

    aspw_pkg::t_cmd r_mem [2];
    logic           r_wr_ptr, n_wr_ptr;
    logic           r_rd_ptr, n_rd_ptr;
    logic [1:0]     r_count,  n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/aspw_back.sv =====
module aspw_back #(
    parameter int BANK_WORDS   = 512,
    parameter int PACKET_WORDS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  aspw_pkg::t_cmd                i_cmd,
    output logic                          o_cmd_pop,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic                          o_write_enable,
    output logic                          o_write_bank,
    output logic [aspw_pkg::ADDR_W-1:0]   o_write_address,
    output logic [aspw_pkg::SAMPLE_W-1:0] o_write_data,
    output logic                          o_start_playback,
    output logic [aspw_pkg::FREE_W-1:0]   o_free_packets,
    output logic                          o_packet_dropped
);

    localparam int CREDITS_PER_BANK = BANK_WORDS / PACKET_WORDS;
    localparam int CREDIT_LIMIT     = 2 * CREDITS_PER_BANK;
    localparam int CREDIT_W         = (CREDIT_LIMIT < 2) ? 1 : $clog2(CREDIT_LIMIT + 1);
    localparam int HEAD_W           = $clog2(BANK_WORDS);
    localparam int WIP_W            = (PACKET_WORDS < 2) ? 1 : $clog2(PACKET_WORDS);

    logic [CREDIT_W-1:0] r_credit,    n_credit;
    logic                r_head_bank, n_head_bank;
    logic [HEAD_W-1:0]   r_head_word, n_head_word;
    logic [WIP_W-1:0]    r_wip,       n_wip;
    logic                r_kept,      n_kept;
    logic                r_kick,      n_kick;
    logic                r_active,    n_active;

    logic                        r_out_valid, n_out_valid;
    logic                        r_we,      n_we;
    logic                        r_wb,      n_wb;
    logic [aspw_pkg::ADDR_W-1:0] r_wa,      n_wa;
    logic [aspw_pkg::SAMPLE_W-1:0] r_wd,    n_wd;
    logic                        r_sp,      n_sp;
    logic [aspw_pkg::FREE_W-1:0] r_free,    n_free;
    logic                        r_dropped, n_dropped;

    logic                take;
    logic [CREDIT_W:0]   credit_sum;
    logic [31:0]         addr_ext;
    logic [31:0]         free_ext;

    // take a command when the output register is empty or being drained
    assign take      = i_cmd_valid && (!r_out_valid || !i_stall);
    assign o_cmd_pop = take;

    assign credit_sum = {1'b0, r_credit} + (CREDIT_W + 1)'(CREDITS_PER_BANK);
    assign addr_ext   = 32'(r_head_word);

    // state update and result for one command
    always_comb begin
        n_credit    = r_credit;
        n_head_bank = r_head_bank;
        n_head_word = r_head_word;
        n_wip       = r_wip;
        n_kept      = r_kept;
        n_kick      = r_kick;
        n_active    = r_active;
        n_we        = 1'b0;
        n_wb        = 1'b0;
        n_wa        = '0;
        n_wd        = '0;
        n_sp        = 1'b0;
        n_dropped   = 1'b0;

        if (i_cmd.is_word) begin
            // credit is taken on the first word of a packet
            if (r_wip == '0) begin
                if (r_active && (r_credit != '0)) begin
                    n_credit = r_credit - CREDIT_W'(1);
                    n_kept   = 1'b1;
                end else begin
                    n_kept   = 1'b0;
                end
            end
            if (n_kept) begin
                n_we = 1'b1;
                n_wb = r_head_bank;
                n_wa = addr_ext[aspw_pkg::ADDR_W-1:0];
                n_wd = i_cmd.dac_code;
                if (r_head_word == HEAD_W'(BANK_WORDS - 1)) begin
                    n_head_word = '0;
                    n_head_bank = ~r_head_bank;
                    if (r_kick) begin
                        n_sp   = 1'b1;
                        n_kick = 1'b0;
                    end
                end else begin
                    n_head_word = r_head_word + HEAD_W'(1);
                end
            end else begin
                n_dropped = 1'b1;
            end
            // packet framing
            if (r_wip == WIP_W'(PACKET_WORDS - 1)) begin
                n_wip = '0;
            end else begin
                n_wip = r_wip + WIP_W'(1);
            end
        end else if (i_cmd.is_done) begin
            // while streaming, return one bank of credits, saturating at two banks
            if (r_active) begin
                if (credit_sum > (CREDIT_W + 1)'(CREDIT_LIMIT)) begin
                    n_credit = CREDIT_W'(CREDIT_LIMIT);
                end else begin
                    n_credit = credit_sum[CREDIT_W-1:0];
                end
            end
        end else if (i_cmd.is_start) begin
            n_active    = 1'b1;
            n_kick      = 1'b1;
            n_credit    = CREDIT_W'(CREDIT_LIMIT);
            n_head_bank = 1'b0;
            n_head_word = '0;
            n_wip       = '0;
            n_kept      = 1'b0;
        end else begin
            n_active = 1'b0;
            n_kick   = 1'b0;
        end
    end

    assign free_ext = 32'(n_credit);
    assign n_free   = free_ext[aspw_pkg::FREE_W-1:0];

    // output valid follows takes and drains
    always_comb begin
        n_out_valid = r_out_valid;
        if (take) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit    <= '0;
            r_head_bank <= 1'b0;
            r_head_word <= '0;
            r_wip       <= '0;
            r_kept      <= 1'b0;
            r_kick      <= 1'b0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (take) begin
                r_credit    <= n_credit;
                r_head_bank <= n_head_bank;
                r_head_word <= n_head_word;
                r_wip       <= n_wip;
                r_kept      <= n_kept;
                r_kick      <= n_kick;
                r_active    <= n_active;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_we      <= n_we;
            r_wb      <= n_wb;
            r_wa      <= n_wa;
            r_wd      <= n_wd;
            r_sp      <= n_sp;
            r_free    <= n_free;
            r_dropped <= n_dropped;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_write_enable   = r_we;
    assign o_write_bank     = r_wb;
    assign o_write_address  = r_wa;
    assign o_write_data     = r_wd;
    assign o_start_playback = r_sp;
    assign o_free_packets   = r_free;
    assign o_packet_dropped = r_dropped;

endmodule

// ===== hw/rtl/audio_stream_ping_pong_writer_unit.sv =====
// a beat accepted at the input is held in the command queue; the back takes it from the queue and registers its result
// throughput: one beat per cycle while the output is not stalled, set by the credit and head update in the back
// a two-entry command queue lets the input keep going while a result waits to be taken
// reset (synchronous, active low): credits, bank head, packet framing, kickstart and
// streaming flags, queue and result valid clear; sample rate goes to 44100, mono mode
module audio_stream_ping_pong_writer_unit #(
    parameter int BANK_WORDS   = 512,
    parameter int PACKET_WORDS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [aspw_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [aspw_pkg::OP_W-1:0]     i_opcode,
    input  logic [aspw_pkg::SAMPLE_W-1:0] i_sample_word,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_write_enable,
    output logic                          o_write_bank,
    output logic [aspw_pkg::ADDR_W-1:0]   o_write_address,
    output logic [aspw_pkg::SAMPLE_W-1:0] o_write_data,
    output logic                          o_start_playback,
    output logic [aspw_pkg::FREE_W-1:0]   o_free_packets,
    output logic                          o_packet_dropped
);

    logic [aspw_pkg::CFG_W-1:0] r_rate;
    logic                       r_stereo_mode;

    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_valid;
    aspw_pkg::t_cmd front_cmd;
    aspw_pkg::t_cmd queue_cmd;

    // held settings for the playback engine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate        <= aspw_pkg::SAMPLE_RATE_RESET;
            r_stereo_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (aspw_pkg::t_cfg_idx'(i_cfg_index))
                aspw_pkg::CFG_SAMPLE_RATE: r_rate        <= i_cfg_data;
                aspw_pkg::CFG_STEREO_MODE: r_stereo_mode <= i_cfg_data[0];
                default: r_stereo_mode <= r_stereo_mode;
            endcase
        end
    end

    aspw_front u_front (
        .i_valid       (i_valid),
        .i_opcode      (i_opcode),
        .i_sample_word (i_sample_word),
        .i_queue_full  (queue_full),
        .o_stall       (o_stall),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    aspw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    aspw_back #(
        .BANK_WORDS   (BANK_WORDS),
        .PACKET_WORDS (PACKET_WORDS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (queue_valid),
        .i_cmd            (queue_cmd),
        .o_cmd_pop        (pop),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_write_enable   (o_write_enable),
        .o_write_bank     (o_write_bank),
        .o_write_address  (o_write_address),
        .o_write_data     (o_write_data),
        .o_start_playback (o_start_playback),
        .o_free_packets   (o_free_packets),
        .o_packet_dropped (o_packet_dropped)
    );

endmodule

// ===== hw/rtl/aspw_checker.sv =====
module aspw_checker #(
    parameter int BANK_WORDS = 512
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_write_enable,
    input logic                          o_write_bank,
    input logic [aspw_pkg::ADDR_W-1:0]   o_write_address,
    input logic [aspw_pkg::SAMPLE_W-1:0] o_write_data,
    input logic                          o_start_playback,
    input logic [aspw_pkg::FREE_W-1:0]   o_free_packets,
    input logic                          o_packet_dropped
);

    localparam int LAST_ADDR = (BANK_WORDS - 1) % (2 ** aspw_pkg::ADDR_W);

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_write_data) && $stable(o_free_packets)
                               && $stable(o_write_enable) && $stable(o_write_address))
        else $error("result beat changed under stall");

    // no write means zero write fields
    a_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_write_enable |-> !o_write_bank && o_write_address == '0
                                       && o_write_data == '0)
        else $error("write fields set without write enable");

    // a dropped word is never written
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_packet_dropped |-> !o_write_enable)
        else $error("dropped word written");

    // playback start only on the word that fills a bank
    a_kick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_start_playback |-> o_write_enable
            && o_write_address == aspw_pkg::ADDR_W'(LAST_ADDR))
        else $error("playback start away from bank fill");

endmodule

bind audio_stream_ping_pong_writer_unit aspw_checker #(
    .BANK_WORDS (BANK_WORDS)
) u_aspw_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_write_enable   (o_write_enable),
    .o_write_bank     (o_write_bank),
    .o_write_address  (o_write_address),
    .o_write_data     (o_write_data),
    .o_start_playback (o_start_playback),
    .o_free_packets   (o_free_packets),
    .o_packet_dropped (o_packet_dropped)
);

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BANK_WORDS       = 512;
    localparam int PACKET_WORDS     = 16;
    localparam int CREDITS_PER_BANK = BANK_WORDS / PACKET_WORDS;
    localparam int CREDIT_LIMIT     = 2 * CREDITS_PER_BANK;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int HOLD_CYCLES      = 80;

    // one bank write result as seen on the output side
    typedef struct {
        logic                          we;
        logic                          bank;
        logic [aspw_pkg::ADDR_W-1:0]   addr;
        logic [aspw_pkg::SAMPLE_W-1:0] data;
        logic                          kick;
        logic [aspw_pkg::FREE_W-1:0]   free;
        logic                          dropped;
    } t_bank_write;

    logic                          i_clk;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_we      = 1'b0;
    logic                          i_cfg_index   = aspw_pkg::CFG_SAMPLE_RATE;
    logic [aspw_pkg::CFG_W-1:0]    i_cfg_data    = '0;
    logic                          i_valid       = 1'b0;
    logic [aspw_pkg::OP_W-1:0]     i_opcode      = aspw_pkg::OP_WORD;
    logic [aspw_pkg::SAMPLE_W-1:0] i_sample_word = '0;
    logic                          i_stall       = 1'b0;
    logic                          o_stall;
    logic                          o_valid;
    logic                          o_write_enable;
    logic                          o_write_bank;
    logic [aspw_pkg::ADDR_W-1:0]   o_write_address;
    logic [aspw_pkg::SAMPLE_W-1:0] o_write_data;
    logic                          o_start_playback;
    logic [aspw_pkg::FREE_W-1:0]   o_free_packets;
    logic                          o_packet_dropped;

    // writer state mirrored by the testbench
    int unsigned credits    = 0;
    logic        head_bank  = 1'b0;
    int unsigned head_word  = 0;
    int unsigned pkt_word   = 0;
    bit          pkt_kept   = 1'b0;
    bit          kick_armed = 1'b0;
    bit          streaming  = 1'b0;
    logic [aspw_pkg::CFG_W-1:0] rate_reg   = aspw_pkg::SAMPLE_RATE_RESET;
    logic                       stereo_reg = 1'b0;

    t_bank_write writes_due[$];

    bit          idling   = 1'b1;
    bit          hold_req = 1'b0;
    int unsigned mismatches  = 0;
    int unsigned beats_sent  = 0;
    int unsigned words_kept  = 0;
    int unsigned words_drop  = 0;
    int unsigned kicks_seen  = 0;
    int unsigned cycle_count = 0;

    audio_stream_ping_pong_writer_unit #(
        .BANK_WORDS  (BANK_WORDS),
        .PACKET_WORDS(PACKET_WORDS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_sample_word   (i_sample_word),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_write_enable  (o_write_enable),
        .o_write_bank    (o_write_bank),
        .o_write_address (o_write_address),
        .o_write_data    (o_write_data),
        .o_start_playback(o_start_playback),
        .o_free_packets  (o_free_packets),
        .o_packet_dropped(o_packet_dropped)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // advance the writer state by one beat and queue the bank write it produces
    task automatic bank_writer_step(input aspw_pkg::t_op op,
                                    input logic [aspw_pkg::SAMPLE_W-1:0] sample);
        t_bank_write w;
        w = '{we: 1'b0, bank: 1'b0, addr: '0, data: '0, kick: 1'b0, free: '0,
              dropped: 1'b0};
        case (op)
            aspw_pkg::OP_WORD: begin
                // credit is taken at the first word of a packet
                if (pkt_word == 0) begin
                    pkt_kept = streaming && credits > 0;
                    if (pkt_kept)
                        credits--;
                end
                if (pkt_kept) begin
                    w.we   = 1'b1;
                    w.bank = head_bank;
                    w.addr = aspw_pkg::ADDR_W'(head_word);
                    w.data = sample ^ aspw_pkg::SIGN_FLIP;
                    head_word++;
                    // bank full: swap banks, first swap after start kicks playback
                    if (head_word >= BANK_WORDS) begin
                        head_word = 0;
                        head_bank = ~head_bank;
                        if (kick_armed) begin
                            w.kick     = 1'b1;
                            kick_armed = 1'b0;
                        end
                    end
                end else begin
                    w.dropped = 1'b1;
                end
                pkt_word = (pkt_word + 1) % PACKET_WORDS;
            end
            aspw_pkg::OP_DONE: begin
                if (streaming) begin
                    credits += CREDITS_PER_BANK;
                    if (credits > CREDIT_LIMIT)
                        credits = CREDIT_LIMIT;
                end
            end
            aspw_pkg::OP_START: begin
                streaming  = 1'b1;
                kick_armed = 1'b1;
                credits    = CREDIT_LIMIT;
                head_bank  = 1'b0;
                head_word  = 0;
                pkt_word   = 0;
                pkt_kept   = 1'b0;
            end
            default: begin
                streaming  = 1'b0;
                kick_armed = 1'b0;
            end
        endcase
        w.free = aspw_pkg::FREE_W'(credits);
        writes_due.push_back(w);
    endtask

    // one input beat, with an optional gap in front
    task automatic send_beat(input aspw_pkg::t_op op,
                             input logic [aspw_pkg::SAMPLE_W-1:0] sample);
        int gap;
        if (idling && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 19);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_sample_word <= sample;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bank_writer_step(op, sample);
        beats_sent++;
    endtask

    task automatic send_packet(input int n_words);
        for (int i = 0; i < n_words; i++)
            send_beat(aspw_pkg::OP_WORD, aspw_pkg::SAMPLE_W'($urandom));
    endtask

    // drop valid and wait until every result is back
    task automatic wait_drain();
        i_valid <= 1'b0;
        while (writes_due.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // register writes, only while the block is idle
    task automatic load_regs(input logic [aspw_pkg::CFG_W-1:0] rate, input logic stereo);
        wait_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= aspw_pkg::CFG_SAMPLE_RATE;
        i_cfg_data  <= rate;
        @(posedge i_clk);
        i_cfg_index <= aspw_pkg::CFG_STEREO_MODE;
        i_cfg_data  <= aspw_pkg::CFG_W'(stereo);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        rate_reg   = rate;
        stereo_reg = stereo;
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t %s: expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    // compare each result beat with the oldest expected write
    always @(posedge i_clk) begin
        t_bank_write w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (writes_due.size() == 0) begin
                mismatches++;
                $display("%0t unexpected result beat: expected none, actual addr %0h data %0h",
                         $time, o_write_address, o_write_data);
            end else begin
                w = writes_due.pop_front();
                check_field("write_enable", w.we, o_write_enable);
                check_field("write_bank", w.bank, o_write_bank);
                check_field("write_address", w.addr, o_write_address);
                check_field("write_data", w.data, o_write_data);
                check_field("start_playback", w.kick, o_start_playback);
                check_field("free_packets", w.free, o_free_packets);
                check_field("packet_dropped", w.dropped, o_packet_dropped);
                if (o_write_enable)   words_kept++;
                if (o_packet_dropped) words_drop++;
                if (o_start_playback) kicks_seen++;
            end
        end
    end

    // result side stalls: random bursts, or one long hold on request
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                i_stall <= 1'b0;
            end else if (idling && $urandom_range(0, 11) == 0) begin
                n = $urandom_range(1, 19);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // corner cases: idle words, ignored done, saturation, restart, stop mid packet
    task automatic test_directed();
        send_beat(aspw_pkg::OP_WORD, 16'h1234);
        send_beat(aspw_pkg::OP_DONE, 16'h0000);
        send_beat(aspw_pkg::OP_STOP, 16'hFFFF);
        send_beat(aspw_pkg::OP_START, 16'h0000);
        send_beat(aspw_pkg::OP_WORD, 16'h0000);
        send_beat(aspw_pkg::OP_WORD, 16'hFFFF);
        send_beat(aspw_pkg::OP_WORD, 16'h8000);
        send_beat(aspw_pkg::OP_WORD, 16'h7FFF);
        send_beat(aspw_pkg::OP_WORD, 16'h5555);
        send_beat(aspw_pkg::OP_WORD, 16'hAAAA);
        send_beat(aspw_pkg::OP_DONE, 16'hFFFF);
        send_beat(aspw_pkg::OP_START, 16'hFFFF);
        send_beat(aspw_pkg::OP_WORD, 16'hFFFF);
        send_beat(aspw_pkg::OP_WORD, 16'h0001);
        send_beat(aspw_pkg::OP_WORD, 16'hFFFE);
        send_beat(aspw_pkg::OP_STOP, 16'h0000);
        send_packet(4);
        send_beat(aspw_pkg::OP_DONE, 16'h0000);
        send_beat(aspw_pkg::OP_START, 16'h0000);
        send_packet(2);
    endtask

    // long stream: bank swaps, kickstart, credit exhaustion, refill
    task automatic test_stream();
        send_beat(aspw_pkg::OP_START, aspw_pkg::SAMPLE_W'($urandom));
        send_packet(CREDIT_LIMIT * PACKET_WORDS);
        send_packet(2 * PACKET_WORDS);
        send_beat(aspw_pkg::OP_DONE, aspw_pkg::SAMPLE_W'($urandom));
        send_packet(3 * PACKET_WORDS);
    endtask

    // random mix of mostly whole packets with control beats and broken packets
    task automatic test_random_mix(input int n_beats);
        int first;
        int r;
        first = beats_sent;
        send_beat(aspw_pkg::OP_START, aspw_pkg::SAMPLE_W'($urandom));
        while (beats_sent - first < n_beats) begin
            idling = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 65)
                send_packet(PACKET_WORDS);
            else if (r < 75)
                send_packet($urandom_range(1, PACKET_WORDS - 1));
            else if (r < 85)
                send_beat(aspw_pkg::OP_DONE, aspw_pkg::SAMPLE_W'($urandom));
            else if (r < 92)
                send_beat(aspw_pkg::OP_START, aspw_pkg::SAMPLE_W'($urandom));
            else
                send_beat(aspw_pkg::OP_STOP, aspw_pkg::SAMPLE_W'($urandom));
        end
        idling = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        idling   = 1'b0;
        hold_req = 1'b1;
        send_beat(aspw_pkg::OP_START, aspw_pkg::SAMPLE_W'($urandom));
        send_packet(2 * PACKET_WORDS);
        send_beat(aspw_pkg::OP_DONE, aspw_pkg::SAMPLE_W'($urandom));
        send_packet(2 * PACKET_WORDS);
    endtask

    // main sequence
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        load_regs('0, 1'b1);
        test_stream();
        load_regs('1, 1'b0);
        test_random_mix(220);
        load_regs(aspw_pkg::CFG_W'($urandom), 1'($urandom));
        test_backpressure();

        wait_drain();
        repeat (8) @(posedge i_clk);
        if (writes_due.size() != 0) begin
            mismatches++;
            $display("%0t %0d expected results never arrived", $time, writes_due.size());
        end
        $display("covered %0d beats: %0d bank writes, %0d dropped words, %0d playback kicks",
                 beats_sent, words_kept, words_drop, kicks_seen);
        $display("register settings ended at rate %0d, stereo %0d", rate_reg, stereo_reg);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
